[hdl/swmf_pkg.sv]
// Shared types and constants for the sliding-window median filter.
package swmf_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int WS_W           = 5;
    localparam int AGE_W          = WS_W;
    localparam int FILL_W         = WS_W;
    localparam int DEF_MAX_WINDOW = 31;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic [WS_W-1:0] WS_RESET = WS_W'(5);

    // register index taken from paddr[2]
    localparam logic REG_WINDOW_SIZE = 1'b0;

    // registered contents of one cell
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] val;
        logic [AGE_W-1:0]           age;
        logic                       valid;
    } cell_t;

    // a cell's entry after eviction, handed up to the next cell
    typedef struct packed {
        cell_t c;
        logic  le;    // entry valid and not above the new sample
    } rview_t;

    // broadcast control to every cell
    typedef struct packed {
        logic                       upd;
        logic                       flush;
        logic                       wipe;
        logic signed [SAMPLE_W-1:0] sample;
        logic [AGE_W-1:0]           last_age;
    } chain_ctl_t;

endpackage

[hdl/swmf_cell.sv]
// One cell of the sorted chain: holds one window sample and its age.
module swmf_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  swmf_pkg::chain_ctl_t ctl,
    input  swmf_pkg::cell_t     upper,
    input  swmf_pkg::rview_t    lower_r,
    input  logic                evict_in,
    output logic                evict_out,
    output swmf_pkg::rview_t    rv,
    output swmf_pkg::cell_t     st
);

    swmf_pkg::cell_t st_reg;
    swmf_pkg::cell_t st_next;
    swmf_pkg::cell_t r;
    logic            own_v;
    logic            up_v;
    logic            e_self;

    assign own_v     = st_reg.valid & ~ctl.flush;
    assign up_v      = upper.valid & ~ctl.flush;
    assign e_self    = own_v && (st_reg.age == ctl.last_age);
    assign evict_out = evict_in | e_self;

    // entry at this slot once the oldest sample is gone
    always_comb
    begin
        if (evict_out)
        begin
            r.val   = upper.val;
            r.age   = upper.age;
            r.valid = up_v;
        end
        else
        begin
            r.val   = st_reg.val;
            r.age   = st_reg.age;
            r.valid = own_v;
        end
    end

    assign rv.c  = r;
    assign rv.le = r.valid && ($signed(r.val) <= $signed(ctl.sample));

    // insert the new sample at the first slot above all smaller-or-equal entries
    always_comb
    begin
        if (rv.le)
        begin
            st_next     = r;
            st_next.age = r.age + swmf_pkg::AGE_W'(1);
        end
        else if (lower_r.le)
        begin
            st_next.val   = ctl.sample;
            st_next.age   = '0;
            st_next.valid = 1'b1;
        end
        else
        begin
            st_next     = lower_r.c;
            st_next.age = lower_r.c.age + swmf_pkg::AGE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (ctl.wipe)
        begin
            st_reg.valid <= 1'b0;
        end
        else if (ctl.upd)
        begin
            st_reg <= st_next;
        end
    end

    assign st = st_reg;

endmodule

[hdl/swmf_chain.sv]
// Row of sorted cells plus the rank select that picks the median.
module swmf_chain #(
    parameter int NUM_CELLS = swmf_pkg::DEF_MAX_WINDOW
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  swmf_pkg::chain_ctl_t                ctl,
    input  logic [swmf_pkg::FILL_W-1:0]         sel_idx,
    output logic signed [swmf_pkg::SAMPLE_W-1:0] median
);

    swmf_pkg::cell_t  st [NUM_CELLS];
    swmf_pkg::cell_t  up [NUM_CELLS];
    swmf_pkg::rview_t rv [NUM_CELLS];
    swmf_pkg::rview_t lo [NUM_CELLS];
    logic             ev [NUM_CELLS+1];

    assign ev[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < NUM_CELLS; g++)
        begin : g_cell
            if (g == NUM_CELLS - 1)
            begin : g_top
                assign up[g] = '0;
            end
            else
            begin : g_mid
                assign up[g] = st[g+1];
            end

            // bottom cell always sees an insertion point below it
            if (g == 0)
            begin : g_bot
                always_comb
                begin
                    lo[g]    = '0;
                    lo[g].le = 1'b1;
                end
            end
            else
            begin : g_up
                assign lo[g] = rv[g-1];
            end

            swmf_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .upper     (up[g]),
                .lower_r   (lo[g]),
                .evict_in  (ev[g]),
                .evict_out (ev[g+1]),
                .rv        (rv[g]),
                .st        (st[g])
            );
        end
    endgenerate

    always_comb
    begin
        median = '0;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            if (int'(sel_idx) == i)
            begin
                median = st[i].val;
            end
        end
    end

endmodule

[hdl/sliding_window_median_filter.sv]
// Top level of the sliding-window running median filter.
//
// Input channel: sample and restart, moved by in_valid/in_ready. Each
// transaction yields exactly one output transaction (median, config_error)
// on out_valid/out_ready, in order.
// The window is held as a chain of MAX_WINDOW cells kept sorted by value;
// each accepted sample evicts the oldest entry (once the window is full) and
// is inserted at its rank in the same cycle. The median is the cell at rank
// fill_count/2, the upper median during warm-up with an even count.
// The chain and the select stage load at the accepting edge; out_valid
// rises when the output register loads from them, once the slot is free.
// Throughput: one transaction per cycle while the receiver keeps up, as the
// cell chain evicts and inserts at the accepting edge itself.
// A stalled receiver holds the result in the output register; one further
// accepted transaction waits in the select stage, then in_ready drops.
// Reset clears the window, the fill count and window_size (to 5). A restart
// transaction, or any APB write to window_size, also empties the window.
// An even, zero or oversize window_size gives median 0 with config_error
// set and leaves the window untouched.
module sliding_window_median_filter #(
    parameter int MAX_WINDOW = swmf_pkg::DEF_MAX_WINDOW
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // APB register port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [swmf_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [swmf_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [swmf_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready,
    // sample channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [swmf_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                  restart,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [swmf_pkg::SAMPLE_W-1:0]  median,
    output logic                                  config_error
);

    logic [swmf_pkg::WS_W-1:0]            ws_reg;
    logic [swmf_pkg::FILL_W-1:0]          fill_reg;
    logic [swmf_pkg::FILL_W-1:0]          fill_next;
    logic                                 pend_reg;
    logic                                 pend_err_reg;
    logic                                 out_valid_reg;
    logic signed [swmf_pkg::SAMPLE_W-1:0] median_reg;
    logic                                 config_error_reg;

    logic                                 cfg_wr;
    logic                                 win_ok;
    logic                                 slot_free;
    logic                                 accept;
    logic                                 take;
    logic signed [swmf_pkg::SAMPLE_W-1:0] chain_med;
    logic [swmf_pkg::FILL_W-1:0]          base_fill;
    swmf_pkg::chain_ctl_t                 ctl;

    // APB: single register, index from paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == swmf_pkg::REG_WINDOW_SIZE);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == swmf_pkg::REG_WINDOW_SIZE)
        begin
            prdata = swmf_pkg::APB_DATA_W'(ws_reg);
        end
    end

    assign win_ok = (ws_reg != '0) && ws_reg[0] && (int'(ws_reg) <= MAX_WINDOW);

    // handshake: select stage frees whenever the output slot can take it
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = !pend_reg || slot_free;
    assign accept    = in_valid && in_ready;
    assign take      = pend_reg && slot_free;

    // fill count saturates at the window size
    always_comb
    begin
        base_fill = restart ? '0 : fill_reg;
        fill_next = base_fill;
        if (base_fill < ws_reg)
        begin
            fill_next = base_fill + swmf_pkg::FILL_W'(1);
        end
    end

    always_comb
    begin
        ctl.upd      = accept && win_ok && !cfg_wr;
        ctl.flush    = restart;
        ctl.wipe     = cfg_wr;
        ctl.sample   = sample;
        ctl.last_age = ws_reg - swmf_pkg::WS_W'(1);
    end

    swmf_chain #(
        .NUM_CELLS (MAX_WINDOW)
    ) u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .sel_idx (fill_reg >> 1),
        .median  (chain_med)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg        <= swmf_pkg::WS_RESET;
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_err_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                ws_reg   <= pwdata[swmf_pkg::WS_W-1:0];
                fill_reg <= '0;
            end
            else if (ctl.upd)
            begin
                fill_reg <= fill_next;
            end

            if (accept)
            begin
                pend_reg     <= 1'b1;
                pend_err_reg <= !win_ok;
            end
            else if (take)
            begin
                pend_reg <= 1'b0;
            end

            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload: loaded from the chain before the next sample lands
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            median_reg       <= pend_err_reg ? '0 : chain_med;
            config_error_reg <= pend_err_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign median       = median_reg;
    assign config_error = config_error_reg;

endmodule

[test/tb_sliding_window_median_filter.sv]
// Self-checking testbench for the sliding-window running median filter.
module tb_sliding_window_median_filter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1100;
    localparam int SETTLE_CYCLES  = 4;     // idle time after a drain, before a register write

    // register map: index from paddr[2], byte address 4*index
    localparam logic [swmf_pkg::APB_ADDR_W-1:0] WINDOW_SIZE_ADDR =
        {swmf_pkg::REG_WINDOW_SIZE, 2'b00};
    localparam logic [swmf_pkg::APB_ADDR_W-1:0] UNMAPPED_ADDR    =
        {~swmf_pkg::REG_WINDOW_SIZE, 2'b00};

    typedef struct {
        logic signed [swmf_pkg::SAMPLE_W-1:0] smp;
        logic                                 rst;
    } sample_txn_t;

    typedef struct {
        logic signed [swmf_pkg::SAMPLE_W-1:0] med;
        logic                                 err;
    } median_result_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 psel = 1'b0;
    logic                                 penable = 1'b0;
    logic                                 pwrite = 1'b0;
    logic [swmf_pkg::APB_ADDR_W-1:0]      paddr = '0;
    logic [swmf_pkg::APB_DATA_W-1:0]      pwdata = '0;
    logic [swmf_pkg::APB_DATA_W-1:0]      prdata;
    logic                                 pready;
    logic                                 in_valid = 1'b0;
    logic                                 in_ready;
    logic signed [swmf_pkg::SAMPLE_W-1:0] sample = '0;
    logic                                 restart = 1'b0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic signed [swmf_pkg::SAMPLE_W-1:0] median;
    logic                                 config_error;

    sliding_window_median_filter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .median       (median),
        .config_error (config_error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the ring store and window setting
    // ------------------------------------------------------------------
    logic signed [swmf_pkg::SAMPLE_W-1:0] ring [swmf_pkg::DEF_MAX_WINDOW];
    int                                   ring_wr;
    int                                   ring_fill;
    logic [swmf_pkg::WS_W-1:0]            win_len = swmf_pkg::WS_RESET;

    sample_txn_t    sample_q[$];      // samples waiting for the driver
    median_result_t median_q[$];      // predicted results, oldest first

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic in_taken = 1'b0;            // input transaction completed at last rising edge
    int  mismatches = 0;
    int  quiet_cycles = 0;
    logic signed [swmf_pkg::SAMPLE_W-1:0] last_smp = '0;

    function automatic void empty_ring();
        for (int i = 0; i < swmf_pkg::DEF_MAX_WINDOW; i++)
        begin
            ring[i] = '0;
        end
        ring_wr   = 0;
        ring_fill = 0;
    endfunction

    // Insert one sample and return the median of the window (upper median while
    // an even number of samples is held during warm-up). A zero or even window
    // flags an error and leaves everything alone, restart included.
    function automatic median_result_t predict_median(
        logic signed [swmf_pkg::SAMPLE_W-1:0] smp,
        logic rst);
        median_result_t                       r;
        logic signed [swmf_pkg::SAMPLE_W-1:0] ranked [swmf_pkg::DEF_MAX_WINDOW];
        logic signed [swmf_pkg::SAMPLE_W-1:0] v;
        int                                   p;
        r.med = '0;
        r.err = 1'b1;
        if (win_len == '0 || !win_len[0])
            return r;
        if (rst)
            empty_ring();
        ring[ring_wr] = smp;
        ring_wr = (ring_wr + 1 >= int'(win_len)) ? 0 : ring_wr + 1;
        if (ring_fill < int'(win_len))
            ring_fill++;
        for (int i = 0; i < ring_fill; i++)
        begin
            ranked[i] = ring[i];
        end
        for (int i = 1; i < ring_fill; i++)
        begin
            v = ranked[i];
            p = i;
            while (p > 0 && ranked[p-1] > v)
            begin
                ranked[p] = ranked[p-1];
                p--;
            end
            ranked[p] = v;
        end
        r.med = ranked[ring_fill / 2];
        r.err = 1'b0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: inputs move on the falling edge only. Valid holds with a
    // stable payload until the transaction is taken.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : driver
        sample_txn_t txn;
        if (!in_valid || in_taken)
        begin
            if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                txn = sample_q.pop_front();
                sample   <= txn.smp;
                restart  <= txn.rst;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: samples both channels at the rising edge, predicts on each
    // input transaction, checks each output transaction in order.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        median_result_t want;
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (median_q.size() == 0)
                begin
                    $display("%0t: unexpected result median %0d config_error %0b",
                             $time, median, config_error);
                    mismatches++;
                end
                else
                begin
                    want = median_q.pop_front();
                    if (median !== want.med)
                    begin
                        $display("%0t: median expected %0d actual %0d",
                                 $time, want.med, median);
                        mismatches++;
                    end
                    if (config_error !== want.err)
                    begin
                        $display("%0t: config_error expected %0b actual %0b",
                                 $time, want.err, config_error);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
                median_q.push_back(predict_median(sample, restart));

            // watchdog on handshake progress
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_sample(input logic signed [swmf_pkg::SAMPLE_W-1:0] smp,
                               input logic rst);
        sample_txn_t txn;
        txn.smp = smp;
        txn.rst = rst;
        sample_q.push_back(txn);
    endtask

    // Block until every queued sample is taken and every result has come back,
    // then let the pipeline settle so a register write finds it idle.
    task automatic drain();
        while (sample_q.size() != 0 || in_valid || median_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write with setup and access phases; the predictor follows the same decode.
    task automatic apb_write(input logic [swmf_pkg::APB_ADDR_W-1:0] addr,
                             input logic [swmf_pkg::APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == swmf_pkg::REG_WINDOW_SIZE)
        begin
            win_len = data[swmf_pkg::WS_W-1:0];
            empty_ring();
        end
    endtask

    task automatic set_window(input logic [swmf_pkg::WS_W-1:0] len);
        apb_write(WINDOW_SIZE_ADDR,
                  {(swmf_pkg::APB_DATA_W - swmf_pkg::WS_W)'($urandom), len});
    endtask

    // mostly full-range, some clustered values so ranks tie, some extremes
    function automatic logic signed [swmf_pkg::SAMPLE_W-1:0] pick_sample();
        logic signed [swmf_pkg::SAMPLE_W-1:0] s;
        case ($urandom_range(9))
            5, 6, 7: s = swmf_pkg::SAMPLE_W'($signed($urandom_range(16)) - 8);
            8:       s = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            9:       s = last_smp;
            default: s = swmf_pkg::SAMPLE_W'($urandom);
        endcase
        last_smp = s;
        return s;
    endfunction

    function automatic logic [swmf_pkg::WS_W-1:0] pick_window();
        case ($urandom_range(9))
            0:       return swmf_pkg::WS_W'(1);
            1:       return swmf_pkg::WS_W'(swmf_pkg::DEF_MAX_WINDOW);
            2:       return swmf_pkg::WS_W'(3);
            3:       return swmf_pkg::WS_W'(2 * $urandom_range(15));   // zero or even: invalid
            default: return swmf_pkg::WS_W'(2 * $urandom_range(15) + 1);
        endcase
    endfunction

    // idle profile: 0 = sender 23 / receiver 81, 1 = swapped, 2 = no idling
    task automatic set_idle_profile(input int prof);
        case (prof)
            0:
            begin
                send_idle_pct = 23;
                recv_idle_pct = 81;
            end
            1:
            begin
                send_idle_pct = 81;
                recv_idle_pct = 23;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int counted;
        int seg_len;
        logic [swmf_pkg::WS_W-1:0] len;

        empty_ring();
        set_idle_profile(0);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset window of 5, sample extremes, warm-up with even
        // counts, wrap of the ring, then restart mid-stream.
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh0000, 1'b0);
        push_sample(-16'sd1, 1'b0);
        push_sample(16'sd1, 1'b0);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sd100, 1'b1);
        push_sample(16'sd200, 1'b0);
        drain();

        // zero window: error, restart ignored, store left alone
        set_window(swmf_pkg::WS_W'(0));
        push_sample(16'sd123, 1'b1);
        push_sample(-16'sd5, 1'b0);
        drain();
        // even window
        set_window(swmf_pkg::WS_W'(4));
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh8000, 1'b1);
        drain();
        // write to an unmapped register is dropped: window stays at 4
        apb_write(UNMAPPED_ADDR, 32'h0000_0003);
        push_sample(16'sd7, 1'b0);
        drain();
        // narrowest window: median is the sample itself
        set_window(swmf_pkg::WS_W'(1));
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sd42, 1'b1);
        drain();
        // widest window
        set_window(swmf_pkg::WS_W'(swmf_pkg::DEF_MAX_WINDOW));
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh0001, 1'b0);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(-16'sd300, 1'b0);
        drain();

        // Random segments; each ends with the sender holding off until
        // every result is back, and most begin with a new window size.
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            set_idle_profile(counted * 3 / RANDOM_ITEMS);
            if ($urandom_range(9) < 7)
                set_window(pick_window());
            else if ($urandom_range(3) == 0)
                apb_write(UNMAPPED_ADDR, $urandom);
            len = win_len;
            if (len == '0 || !len[0])
            begin
                // invalid window: a few ignored samples, not counted
                seg_len = $urandom_range(12, 4);
                repeat (seg_len) push_sample(pick_sample(), 1'($urandom_range(1)));
            end
            else
            begin
                seg_len = $urandom_range(90, 20);
                repeat (seg_len) push_sample(pick_sample(), $urandom_range(99) < 4);
                counted += seg_len;
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sliding_window_median_filter.f]
hdl/swmf_pkg.sv
hdl/swmf_cell.sv
hdl/swmf_chain.sv
hdl/sliding_window_median_filter.sv
test/tb_sliding_window_median_filter.sv
